// File: rtl/look_at_view_matrix_macros.svh
// assertion macros for the look-at view matrix block
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication, clocked on clk_i and disabled in reset
`define LAVM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("look_at_view_matrix: check failed");

// next-cycle implication, clocked on clk_i and disabled in reset
`define LAVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("look_at_view_matrix: check failed");

`endif

// File: rtl/lavm_pkg.sv
// shared constants and saturation helper for the look-at view matrix block
package lavm_pkg;

  localparam int WORD_W          = 32;
  localparam int WIDE_W          = 128;
  localparam int SUM_W           = 64;
  localparam int SQRT_STEPS      = SUM_W / 2;
  localparam int ROW_W           = 2;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [ROW_W-1:0] ROW_RIGHT = 2'd0;
  localparam logic [ROW_W-1:0] ROW_UP    = 2'd1;
  localparam logic [ROW_W-1:0] ROW_BACK  = 2'd2;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd3;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v,
                                                        input int sat_w);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed((WIDE_W'(1) << (sat_w - 1)) - WIDE_W'(1));
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return WORD_W'(hi);
    end
    if (v < lo) begin
      return WORD_W'(lo);
    end
    return WORD_W'(v);
  endfunction

endpackage

// File: rtl/look_at_view_matrix.sv
// Look-at view matrix: a transfer is taken when start is high and busy is low, and busy then
// stays high while the gap counter runs down to zero. Each item yields four result rows on
// consecutive cycles, marked by result_valid_o. Its path runs through two normalize pipelines
// (a 32-step square root and a FRAC_BITS+1 step divider each) and two cross products. Several
// items are in flight at once. The receiver cannot stall: every row is valid for exactly one
// cycle and must be captured then. degenerate_o is set on all four rows when the view
// direction or the right vector has zero length, and the first three rows then read as zeros.
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix import lavm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] eye_x_i,
  input  logic signed [WORD_W-1:0] eye_y_i,
  input  logic signed [WORD_W-1:0] eye_z_i,
  input  logic signed [WORD_W-1:0] focus_x_i,
  input  logic signed [WORD_W-1:0] focus_y_i,
  input  logic signed [WORD_W-1:0] focus_z_i,
  input  logic signed [WORD_W-1:0] updir_x_i,
  input  logic signed [WORD_W-1:0] updir_y_i,
  input  logic signed [WORD_W-1:0] updir_z_i,
  output logic                     result_valid_o,
  output logic [ROW_W-1:0]         row_index_o,
  output logic signed [WORD_W-1:0] col0_o,
  output logic signed [WORD_W-1:0] col1_o,
  output logic signed [WORD_W-1:0] col2_o,
  output logic signed [WORD_W-1:0] col3_o,
  output logic                     last_row_o,
  output logic                     degenerate_o
);

  localparam int SAT_W = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;
  localparam int UW    = FRAC_BITS + 2;
  localparam int SIDE1 = 6 * WORD_W;
  localparam int SIDE2 = 3 * WORD_W + 3 * UW + 1;
  localparam int SIDE3 = SIDE2 + 3 * UW + 1;

  logic [1:0]               gap_q;
  logic                     accept;
  logic [1:0]               vld_q;
  logic signed [WORD_W-1:0] eye_in [3];
  logic signed [WORD_W-1:0] foc_in [3];
  logic signed [WORD_W-1:0] upd_in [3];
  logic signed [WORD_W-1:0] eye0_q [3];
  logic signed [WORD_W-1:0] foc0_q [3];
  logic signed [WORD_W-1:0] upd0_q [3];
  logic signed [WORD_W-1:0] eye1_q [3];
  logic signed [WORD_W-1:0] upd1_q [3];
  logic signed [WORD_W-1:0] d1_q [3];

  logic [SIDE1-1:0]         side1;
  logic                     n1_valid;
  logic signed [UW-1:0]     back_u [3];
  logic                     n1_ok;
  logic [SIDE1-1:0]         n1_side;
  logic signed [WORD_W-1:0] upd_n1 [3];
  logic [SIDE2-1:0]         side2;
  logic                     c1_valid;
  logic signed [WORD_W-1:0] c1 [3];
  logic [SIDE2-1:0]         c1_side;
  logic                     n2_valid;
  logic signed [UW-1:0]     right_u [3];
  logic                     n2_ok;
  logic [SIDE2-1:0]         n2_side;
  logic signed [WORD_W-1:0] back_w [3];
  logic [SIDE3-1:0]         side3;
  logic                     c2_valid;
  logic signed [WORD_W-1:0] upv_w [3];
  logic [SIDE3-1:0]         c2_side;
  logic signed [WORD_W-1:0] eye_r [3];
  logic signed [UW-1:0]     back_r [3];
  logic signed [UW-1:0]     right_r [3];
  logic                     ok_r;

  assign accept = start && !busy;
  assign busy   = gap_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], accept};
      if (accept) begin
        gap_q <= 2'd3;
      end else if (gap_q != 2'd0) begin
        gap_q <= gap_q - 2'd1;
      end
    end
  end

  assign eye_in = '{eye_x_i, eye_y_i, eye_z_i};
  assign foc_in = '{focus_x_i, focus_y_i, focus_z_i};
  assign upd_in = '{updir_x_i, updir_y_i, updir_z_i};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      eye0_q[i] <= sat_word(WIDE_W'(eye_in[i]), SAT_W);
      foc0_q[i] <= sat_word(WIDE_W'(foc_in[i]), SAT_W);
      upd0_q[i] <= sat_word(WIDE_W'(upd_in[i]), SAT_W);
      eye1_q[i] <= eye0_q[i];
      upd1_q[i] <= upd0_q[i];
      d1_q[i]   <= sat_word(WIDE_W'(eye0_q[i]) - WIDE_W'(foc0_q[i]), SAT_W);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign side1[i*WORD_W +: WORD_W]       = eye1_q[i];
    assign side1[(3+i)*WORD_W +: WORD_W]   = upd1_q[i];
    assign upd_n1[i]                       = n1_side[(3+i)*WORD_W +: WORD_W];
    assign side2[i*WORD_W +: WORD_W]       = n1_side[i*WORD_W +: WORD_W];
    assign side2[3*WORD_W + i*UW +: UW]    = back_u[i];
    assign back_w[i] = WORD_W'($signed(n2_side[3*WORD_W + i*UW +: UW]));
    assign side3[SIDE2 + i*UW +: UW]       = right_u[i];
    assign eye_r[i]   = c2_side[i*WORD_W +: WORD_W];
    assign back_r[i]  = $signed(c2_side[3*WORD_W + i*UW +: UW]);
    assign right_r[i] = $signed(c2_side[SIDE2 + i*UW +: UW]);
  end

  assign side2[SIDE2-1]   = n1_ok;
  assign side3[SIDE2-1:0] = n2_side;
  assign side3[SIDE3-1]   = n2_ok;
  assign ok_r             = c2_side[SIDE3-1] && c2_side[SIDE2-1];

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1)) u_norm_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[1]),
    .v_i     (d1_q),
    .side_i  (side1),
    .valid_o (n1_valid),
    .u_o     (back_u),
    .ok_o    (n1_ok),
    .side_o  (n1_side)
  );

  lavm_cross #(.FRAC_BITS(FRAC_BITS), .SAT_W(SAT_W), .SIDE_W(SIDE2)) u_cross_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n1_valid),
    .a_i     (upd_n1),
    .b_i     (back_u),
    .side_i  (side2),
    .valid_o (c1_valid),
    .c_o     (c1),
    .side_o  (c1_side)
  );

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_valid),
    .v_i     (c1),
    .side_i  (c1_side),
    .valid_o (n2_valid),
    .u_o     (right_u),
    .ok_o    (n2_ok),
    .side_o  (n2_side)
  );

  lavm_cross #(.FRAC_BITS(FRAC_BITS), .SAT_W(SAT_W), .SIDE_W(SIDE3)) u_cross_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n2_valid),
    .a_i     (back_w),
    .b_i     (right_u),
    .side_i  (side3),
    .valid_o (c2_valid),
    .c_o     (upv_w),
    .side_o  (c2_side)
  );

  lavm_rows #(.FRAC_BITS(FRAC_BITS), .SAT_W(SAT_W)) u_rows (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (c2_valid),
    .right_i        (right_r),
    .upv_i          (upv_w),
    .back_i         (back_r),
    .eye_i          (eye_r),
    .ok_i           (ok_r),
    .result_valid_o (result_valid_o),
    .row_index_o    (row_index_o),
    .col0_o         (col0_o),
    .col1_o         (col1_o),
    .col2_o         (col2_o),
    .col3_o         (col3_o),
    .last_row_o     (last_row_o),
    .degenerate_o   (degenerate_o)
  );

  `LAVM_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy)
  `LAVM_ASSERT_NEXT(a_rows_in_burst, result_valid_o && !last_row_o, result_valid_o)
  `LAVM_ASSERT_IMPL(a_degenerate_zero, result_valid_o && degenerate_o && !last_row_o, col0_o == '0 && col3_o == '0)
  `LAVM_ASSERT_IMPL(a_last_is_row3, result_valid_o && last_row_o, row_index_o == ROW_LAST)

endmodule

// File: rtl/lavm_norm.sv
// pipelined vector normalize: squares, square root and per-lane divider
module lavm_norm import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [WORD_W-1:0] v_i [3],
  input  logic        [SIDE_W-1:0] side_i,
  output logic                     valid_o,
  output logic signed [FRAC_BITS+1:0] u_o [3],
  output logic                     ok_o,
  output logic        [SIDE_W-1:0] side_o
);

  localparam int UW        = FRAC_BITS + 2;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int P_SQRT0   = 3;
  localparam int P_NUM     = P_SQRT0 + SQRT_STEPS;
  localparam int P_DIV0    = P_NUM + 1;
  localparam int P_OUT     = P_DIV0 + DIV_STEPS;
  localparam int NS        = P_OUT + 1;

  logic              valid_q [NS];
  logic [SIDE_W-1:0] side_q  [NS];
  logic              neg_q   [NS][3];
  logic [WORD_W-1:0] mag_q   [NS][3];

  logic [SUM_W-1:0]  sq_q [3];
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  s_q [SQRT_STEPS];
  logic [SUM_W-1:0]  r_q [SQRT_STEPS];
  logic [SUM_W-1:0]  num_q [3];
  logic [SUM_W-1:0]  len_q [DIV_STEPS+1];
  logic [SUM_W-1:0]  rem_q [DIV_STEPS][3];
  logic [QW-1:0]     quo_q [DIV_STEPS][3];
  logic signed [UW-1:0] u_q [3];
  logic              ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NS; p++) begin
        valid_q[p] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int p = 1; p < NS; p++) begin
        valid_q[p] <= valid_q[p-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int i = 0; i < 3; i++) begin
      neg_q[0][i] <= v_i[i][WORD_W-1];
      mag_q[0][i] <= v_i[i][WORD_W-1] ? WORD_W'(-v_i[i]) : WORD_W'(v_i[i]);
    end
    for (int p = 1; p < NS; p++) begin
      side_q[p] <= side_q[p-1];
      for (int i = 0; i < 3; i++) begin
        neg_q[p][i] <= neg_q[p-1][i];
        mag_q[p][i] <= mag_q[p-1][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= SUM_W'(mag_q[0][i]) * SUM_W'(mag_q[0][i]);
    end
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] s_in;
    logic [SUM_W-1:0] r_in;
    logic [SUM_W:0]   trial;
    if (k == 0) begin : g_first
      assign s_in = sum_q;
      assign r_in = '0;
    end else begin : g_next
      assign s_in = s_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign trial = {1'b0, r_in} + {1'b0, BIT};
    always_ff @(posedge clk_i) begin
      if ({1'b0, s_in} >= trial) begin
        s_q[k] <= s_in - trial[SUM_W-1:0];
        r_q[k] <= (r_in >> 1) + BIT;
      end else begin
        s_q[k] <= s_in;
        r_q[k] <= r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= (SUM_W'(mag_q[P_NUM-1][i]) << FRAC_BITS) + (r_q[SQRT_STEPS-1] >> 1);
    end
    len_q[0] <= r_q[SQRT_STEPS-1];
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = FRAC_BITS - j;
    logic [SUM_W-1:0] dl;
    assign dl = len_q[j] << SH;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [SUM_W-1:0] rem_in;
      logic [QW-1:0]    quo_in;
      if (j == 0) begin : g_first
        assign rem_in = num_q[i];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1][i];
        assign quo_in = quo_q[j-1][i];
      end
      always_ff @(posedge clk_i) begin
        if (rem_in >= dl) begin
          rem_q[j][i] <= rem_in - dl;
          quo_q[j][i] <= quo_in | (QW'(1) << SH);
        end else begin
          rem_q[j][i] <= rem_in;
          quo_q[j][i] <= quo_in;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      len_q[j+1] <= len_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u_q[i] <= neg_q[P_OUT-1][i] ? -UW'(quo_q[DIV_STEPS-1][i]) : UW'(quo_q[DIV_STEPS-1][i]);
    end
    ok_q <= len_q[DIV_STEPS] != '0;
  end

  assign valid_o = valid_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign u_o     = u_q;
  assign ok_o    = ok_q;

endmodule

// File: rtl/lavm_cross.sv
// pipelined cross product of a word vector with a unit vector, rounded and saturated
module lavm_cross import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SAT_W     = COORD_WIDTH_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [WORD_W-1:0]    a_i [3],
  input  logic signed [FRAC_BITS+1:0] b_i [3],
  input  logic        [SIDE_W-1:0]    side_i,
  output logic                        valid_o,
  output logic signed [WORD_W-1:0]    c_o [3],
  output logic        [SIDE_W-1:0]    side_o
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = WORD_W + UW;
  localparam int DW = PW + 1;
  localparam logic [DW:0] HALF = (DW + 1)'(1) << (FRAC_BITS - 1);

  logic [3:0]           valid_q;
  logic [SIDE_W-1:0]    side_q [4];
  logic signed [PW-1:0] p_q [6];
  logic signed [DW-1:0] diff_q [3];
  logic                 neg_q [3];
  logic [DW:0]          rm_q [3];
  logic signed [WORD_W-1:0] c_q [3];
  logic [DW-1:0]        mag [3];
  logic [DW:0]          rm_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int s = 1; s < 4; s++) begin
      side_q[s] <= side_q[s-1];
    end
    p_q[0] <= a_i[1] * b_i[2];
    p_q[1] <= a_i[2] * b_i[1];
    p_q[2] <= a_i[2] * b_i[0];
    p_q[3] <= a_i[0] * b_i[2];
    p_q[4] <= a_i[0] * b_i[1];
    p_q[5] <= a_i[1] * b_i[0];
    for (int i = 0; i < 3; i++) begin
      diff_q[i] <= DW'(p_q[2*i]) - DW'(p_q[2*i+1]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = diff_q[i][DW-1] ? DW'(-diff_q[i]) : DW'(diff_q[i]);
      rm_d[i] = ({1'b0, mag[i]} + HALF) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg_q[i] <= diff_q[i][DW-1];
      rm_q[i]  <= rm_d[i];
      c_q[i]   <= neg_q[i] ? sat_word(-WIDE_W'(rm_q[i]), SAT_W)
                           : sat_word(WIDE_W'(rm_q[i]), SAT_W);
    end
  end

  assign valid_o = valid_q[3];
  assign side_o  = side_q[3];
  assign c_o     = c_q;

endmodule

// File: rtl/lavm_rows.sv
// translation dot products and row sequencer driving the result ports
module lavm_rows import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SAT_W     = COORD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+1:0] right_i [3],
  input  logic signed [WORD_W-1:0]    upv_i [3],
  input  logic signed [FRAC_BITS+1:0] back_i [3],
  input  logic signed [WORD_W-1:0]    eye_i [3],
  input  logic                        ok_i,
  output logic                        result_valid_o,
  output logic [ROW_W-1:0]            row_index_o,
  output logic signed [WORD_W-1:0]    col0_o,
  output logic signed [WORD_W-1:0]    col1_o,
  output logic signed [WORD_W-1:0]    col2_o,
  output logic signed [WORD_W-1:0]    col3_o,
  output logic                        last_row_o,
  output logic                        degenerate_o
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = WORD_W + UW;
  localparam int DW = PW + 2;
  localparam logic [DW:0] HALF = (DW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [WORD_W-1:0] ONE  = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] ONE_COL = sat_word(WIDE_W'(1) << FRAC_BITS, SAT_W);

  logic [4:0]               vld_q;
  logic                     ok_q [5];
  logic signed [UW-1:0]     unit_q [4][3][3];
  logic signed [WORD_W-1:0] eye_q [3];
  logic signed [PW-1:0]     prod_q [3][3];
  logic signed [DW-1:0]     dot_q [3];
  logic                     neg_q [3];
  logic [DW:0]              rm_q [3];
  logic signed [WORD_W-1:0] col_q [3][4];
  logic signed [WORD_W-1:0] buf_q [3][4];
  logic                     buf_ok_q;
  logic                     act_q;
  logic [ROW_W-1:0]         cnt_q;
  logic                     out_vld_q;
  logic [ROW_W-1:0]         row_q;
  logic signed [WORD_W-1:0] out_col_q [4];
  logic                     last_q;
  logic                     degen_q;
  logic [DW-1:0]            mag [3];
  logic [DW:0]              rm_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0] <= ok_i;
    for (int s = 1; s < 5; s++) begin
      ok_q[s] <= ok_q[s-1];
    end
    for (int i = 0; i < 3; i++) begin
      unit_q[0][0][i] <= right_i[i];
      unit_q[0][2][i] <= back_i[i];
      if (upv_i[i] > ONE) begin
        unit_q[0][1][i] <= UW'(ONE);
      end else if (upv_i[i] < -ONE) begin
        unit_q[0][1][i] <= UW'(-ONE);
      end else begin
        unit_q[0][1][i] <= UW'(upv_i[i]);
      end
      eye_q[i] <= eye_i[i];
    end
    for (int s = 1; s < 4; s++) begin
      unit_q[s] <= unit_q[s-1];
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[k][i] <= unit_q[0][k][i] * eye_q[i];
      end
      dot_q[k] <= DW'(prod_q[k][0]) + DW'(prod_q[k][1]) + DW'(prod_q[k][2]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = dot_q[k][DW-1] ? DW'(-dot_q[k]) : DW'(dot_q[k]);
      rm_d[k] = ({1'b0, mag[k]} + HALF) >> FRAC_BITS;
    end
  end

  // col3 is minus the rounded dot product
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      neg_q[k] <= dot_q[k][DW-1];
      rm_q[k]  <= rm_d[k];
      col_q[k][3] <= neg_q[k] ? sat_word(WIDE_W'(rm_q[k]), SAT_W)
                              : sat_word(-WIDE_W'(rm_q[k]), SAT_W);
      for (int i = 0; i < 3; i++) begin
        col_q[k][i] <= sat_word(WIDE_W'(unit_q[3][k][i]), SAT_W);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      buf_q    <= col_q;
      buf_ok_q <= ok_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= act_q;
      if (vld_q[4]) begin
        act_q <= 1'b1;
        cnt_q <= ROW_RIGHT;
      end else if (act_q) begin
        cnt_q <= cnt_q + ROW_W'(1);
        if (cnt_q == ROW_LAST) begin
          act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_q) begin
      row_q   <= cnt_q;
      last_q  <= cnt_q == ROW_LAST;
      degen_q <= !buf_ok_q;
      case (cnt_q)
        ROW_RIGHT, ROW_UP, ROW_BACK: begin
          for (int c = 0; c < 4; c++) begin
            out_col_q[c] <= buf_ok_q ? buf_q[cnt_q][c] : '0;
          end
        end
        default: begin
          out_col_q[0] <= '0;
          out_col_q[1] <= '0;
          out_col_q[2] <= '0;
          out_col_q[3] <= ONE_COL;
        end
      endcase
    end
  end

  assign result_valid_o = out_vld_q;
  assign row_index_o    = row_q;
  assign col0_o         = out_col_q[0];
  assign col1_o         = out_col_q[1];
  assign col2_o         = out_col_q[2];
  assign col3_o         = out_col_q[3];
  assign last_row_o     = last_q;
  assign degenerate_o   = degen_q;

endmodule

// File: tb/view_matrix_checker.sv
// checker module: watches item and row transfers, predicts view matrix rows, compares
`timescale 1ns / 1ps

module view_matrix_checker import lavm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic signed [WORD_W-1:0] eye_x_i,
  input  logic signed [WORD_W-1:0] eye_y_i,
  input  logic signed [WORD_W-1:0] eye_z_i,
  input  logic signed [WORD_W-1:0] focus_x_i,
  input  logic signed [WORD_W-1:0] focus_y_i,
  input  logic signed [WORD_W-1:0] focus_z_i,
  input  logic signed [WORD_W-1:0] updir_x_i,
  input  logic signed [WORD_W-1:0] updir_y_i,
  input  logic signed [WORD_W-1:0] updir_z_i,
  input  logic                     result_valid_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic signed [WORD_W-1:0] col0_i,
  input  logic signed [WORD_W-1:0] col1_i,
  input  logic signed [WORD_W-1:0] col2_i,
  input  logic signed [WORD_W-1:0] col3_i,
  input  logic                     last_row_i,
  input  logic                     degenerate_i,
  output int                       pending_o,
  output int                       errors_o
);

  localparam int SW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic signed [WORD_W-1:0] c0;
    logic signed [WORD_W-1:0] c1;
    logic signed [WORD_W-1:0] c2;
    logic signed [WORD_W-1:0] c3;
    logic                     last;
    logic                     degen;
  } mat_row_t;

  typedef logic signed [63:0] vec3_t [3];

  mat_row_t matrix_rows_q[$];

  function automatic logic signed [63:0] clip(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (SW - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) return 64'(hi);
    if (v < lo) return 64'(lo);
    return 64'(v);
  endfunction

  function automatic logic signed [63:0] unit_clamp(input logic signed [63:0] v);
    logic signed [63:0] one;
    one = 64'sd1 <<< FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
    logic signed [127:0] half;
    half = 128'sd1 <<< (FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> FRAC_BITS;
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic unit_vec(input vec3_t v, output vec3_t u);
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] a;
    logic [127:0] q;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      s = s + a * a;
    end
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      q = ((128'(a) << FRAC_BITS) + 128'(len / 2)) / 128'(len);
      u[i] = unit_clamp((v[i] < 0) ? -$signed(64'(q)) : $signed(64'(q)));
    end
    return 1'b1;
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = clip(round_shift(128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1])));
    c[1] = clip(round_shift(128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2])));
    c[2] = clip(round_shift(128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0])));
  endfunction

  task automatic predict_view_rows();
    vec3_t eye, d, upd, back, right, upv, c;
    vec3_t basis [3];
    logic ok;
    logic signed [127:0] dot;
    mat_row_t r;
    eye[0] = clip(eye_x_i); eye[1] = clip(eye_y_i); eye[2] = clip(eye_z_i);
    d[0] = clip(128'(eye[0]) - 128'(clip(focus_x_i)));
    d[1] = clip(128'(eye[1]) - 128'(clip(focus_y_i)));
    d[2] = clip(128'(eye[2]) - 128'(clip(focus_z_i)));
    upd[0] = clip(updir_x_i); upd[1] = clip(updir_y_i); upd[2] = clip(updir_z_i);
    for (int i = 0; i < 3; i++) begin
      right[i] = 0;
      upv[i] = 0;
    end
    ok = unit_vec(d, back);
    if (ok) begin
      cross_prod(upd, back, c);
      ok = unit_vec(c, right);
    end
    if (ok) begin
      cross_prod(back, right, upv);
      for (int i = 0; i < 3; i++) upv[i] = unit_clamp(upv[i]);
    end
    basis[0] = right;
    basis[1] = upv;
    basis[2] = back;
    for (int k = 0; k < 4; k++) begin
      r = '0;
      r.row = ROW_W'(k);
      r.last = (k == 3);
      r.degen = !ok;
      if (k == 3) begin
        r.c3 = WORD_W'(clip(128'sd1 <<< FRAC_BITS));
      end else if (ok) begin
        dot = 128'(basis[k][0]) * 128'(eye[0]) + 128'(basis[k][1]) * 128'(eye[1])
            + 128'(basis[k][2]) * 128'(eye[2]);
        r.c0 = WORD_W'(clip(basis[k][0]));
        r.c1 = WORD_W'(clip(basis[k][1]));
        r.c2 = WORD_W'(clip(basis[k][2]));
        r.c3 = WORD_W'(clip(-round_shift(dot)));
      end
      matrix_rows_q.push_back(r);
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    mat_row_t got;
    mat_row_t want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (start_i && !busy_i) predict_view_rows();
      if (result_valid_i) begin
        got = '{row_index_i, col0_i, col1_i, col2_i, col3_i, last_row_i, degenerate_i};
        if (matrix_rows_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected row transfer: %p", got);
          errors_o <= errors_o + 1;
        end else begin
          want = matrix_rows_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10) $display("row mismatch: expected %p actual %p", want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = matrix_rows_q.size();

endmodule

// File: tb/testbench.sv
// testbench top: drives camera items into the view matrix block and gives the verdict
`timescale 1ns / 1ps

module testbench;
  import lavm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [WORD_W-1:0] cam [9] = '{default: '0};
  logic result_valid_o;
  logic [ROW_W-1:0] row_index_o;
  logic signed [WORD_W-1:0] col0_o, col1_o, col2_o, col3_o;
  logic last_row_o, degenerate_o;
  int pending, errors;
  int idle_pct;

  always #4 clk_i = ~clk_i;

  look_at_view_matrix DUT (
    .clk_i, .rst_ni, .start, .busy,
    .eye_x_i(cam[0]), .eye_y_i(cam[1]), .eye_z_i(cam[2]),
    .focus_x_i(cam[3]), .focus_y_i(cam[4]), .focus_z_i(cam[5]),
    .updir_x_i(cam[6]), .updir_y_i(cam[7]), .updir_z_i(cam[8]),
    .result_valid_o, .row_index_o, .col0_o, .col1_o, .col2_o, .col3_o,
    .last_row_o, .degenerate_o
  );

  view_matrix_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .eye_x_i(cam[0]), .eye_y_i(cam[1]), .eye_z_i(cam[2]),
    .focus_x_i(cam[3]), .focus_y_i(cam[4]), .focus_z_i(cam[5]),
    .updir_x_i(cam[6]), .updir_y_i(cam[7]), .updir_z_i(cam[8]),
    .result_valid_i(result_valid_o), .row_index_i(row_index_o),
    .col0_i(col0_o), .col1_i(col1_o), .col2_i(col2_o), .col3_i(col3_o),
    .last_row_i(last_row_o), .degenerate_i(degenerate_o),
    .pending_o(pending), .errors_o(errors)
  );

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 511)) - 256);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  task automatic send_camera(input logic [31:0] v [9]);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    for (int i = 0; i < 9; i++) cam[i] <= v[i];
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_random(input int count);
    logic [31:0] v [9];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) v[i] = rand_coord();
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];
        1: for (int i = 0; i < 3; i++) v[6 + i] = v[i] - v[3 + i];
        2: for (int i = 0; i < 3; i++) v[6 + i] = '0;
        default: ;
      endcase
      send_camera(v);
    end
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    logic [31:0] v [9];
    idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: standard camera, degenerate cases, extremes
    v = '{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0};           send_camera(v);
    v = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0}; send_camera(v);
    v = '{0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0};           send_camera(v);
    v = '{0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0};             send_camera(v);
    v = '{0, 0, 5 * ONE, 0, 0, 0, 0, 1, 0};             send_camera(v);
    v = '{MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0}; send_camera(v);
    v = '{MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV}; send_camera(v);
    v = '{MAXV, MINV, MAXV, 0, 0, 0, MINV, MAXV, MINV}; send_camera(v);
    v = '{1, 0, 0, 0, 0, 0, 0, 0, 1};                   send_camera(v);
    v = '{-1, -1, -1, 0, 0, 0, -1, 0, 0};               send_camera(v);
    v = '{32'hffffffff, 0, 0, 32'hffffffff, 0, 0, 0, ONE, 0}; send_camera(v);
    v = '{3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, ONE};     send_camera(v);
    send_random(50);
    idle_pct = 73;
    send_random(55);
    idle_pct = 24;
    send_random(50);
    idle_pct = 0;
    send_random(55);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
